FILE: hw/rtl/bsfrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfrb_pkg: shared types for the byte stuffed frame ring buffer
// Request record, queue entry and sequencer states.
// ----------------------------------------------------------------------------
package bsfrb_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] CSR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_START = 2'd1;
   localparam logic [1:0] CSR_END   = 2'd2;
   localparam logic [1:0] CSR_ESC   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_BROKE = 2'd2;

   typedef enum logic [1:0] {
      MODE_EMPTY  = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_FULL   = 2'd2,
      MODE_OVER   = 2'd3
   } mode_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       is_code;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P_START,
      ST_P_ESC,
      ST_P_DATA,
      ST_P_END,
      ST_HUNT_RD,
      ST_HUNT_CHK,
      ST_RD,
      ST_RD_CHK,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/bsfrb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfrb_front: request intake
// Classifies each request (code byte or not) and queues it, two deep.
// ----------------------------------------------------------------------------
module bsfrb_front
   import bsfrb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_data_in,
   input  wire logic       req_frame_first,
   input  wire logic       req_frame_last,
   input  wire logic [7:0] start_code,
   input  wire logic [7:0] end_code,
   input  wire logic [7:0] escape_code,
   output logic            q_valid,
   input  wire logic       q_take,
   output item_type        q_item
);

   item_type   slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_take && q_valid;

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff].cmd     <= req_command;
         slot_ff[wr_ff].data    <= req_data_in;
         slot_ff[wr_ff].first   <= req_frame_first;
         slot_ff[wr_ff].last    <= req_frame_last;
         slot_ff[wr_ff].is_code <= (req_data_in == start_code) ||
                                   (req_data_in == end_code) ||
                                   (req_data_in == escape_code);
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |=> cnt_ff == 2'd2)
      else $error("full queue changed without take");
   a_empty_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> rd_ff == wr_ff)
      else $error("empty queue pointers differ");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/bsfrb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfrb_back: store sequencer
// Writes stuffed bytes into the ring store and decodes pops, one store
// access per cycle, with a registered response.
// ----------------------------------------------------------------------------
module bsfrb_back
   import bsfrb_pkg::*;
#(
   parameter int STORE_DEPTH = 256
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   output logic            q_take,
   input  item_type        q_item,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data,
   input  wire logic [7:0] start_code,
   input  wire logic [7:0] end_code,
   input  wire logic [7:0] escape_code,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_out,
   output logic            rsp_frame_end,
   output logic [1:0]      rsp_status,
   output logic            rsp_overwritten
);

   localparam int AW = $clog2(STORE_DEPTH);

   logic [7:0]    mem [STORE_DEPTH];
   logic [7:0]    rdata_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   logic [8:0]    size_ff;
   logic [AW:0]   size_lim;
   logic [AW-1:0] widx_ff, widx_in, ridx_ff, ridx_in;
   mode_type      mode_ff, mode_in;
   logic          inf_ff, inf_in;
   state_type     st_ff, st_in;
   item_type      it_ff;
   logic          load;
   logic [AW:0]   hunt_ff, hunt_in;
   logic          dec_ff, dec_in;
   logic [7:0]    d_ff, d_in;
   logic          esc_ff, esc_in;
   logic          ov_ff, ov_in, fe_ff, fe_in, rv_ff, rv_in;
   logic [7:0]    do_ff, do_in;
   logic [1:0]    stat_ff, stat_in;
   logic [AW-1:0] nw, nr;
   logic [7:0]    pb;

   always_comb begin
      if (size_ff == 9'd0) size_lim = (AW+1)'(1);
      else if ({23'd0, size_ff} > 32'(STORE_DEPTH)) size_lim = (AW+1)'(STORE_DEPTH);
      else size_lim = (AW+1)'(size_ff);
   end

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i, input logic [AW:0] lim);
      logic [AW:0] t;
      t = {1'b0, i} + (AW+1)'(1);
      return (t >= lim) ? '0 : t[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   assign q_take = load;
   assign rsp_valid       = rv_ff;
   assign rsp_data_out    = do_ff;
   assign rsp_frame_end   = fe_ff;
   assign rsp_status      = stat_ff;
   assign rsp_overwritten = ov_ff;

   always_comb begin
      st_in = st_ff; widx_in = widx_ff; ridx_in = ridx_ff; mode_in = mode_ff;
      inf_in = inf_ff; hunt_in = hunt_ff; dec_in = dec_ff; d_in = d_ff;
      esc_in = esc_ff; do_in = do_ff; fe_in = fe_ff; stat_in = stat_ff;
      ov_in = ov_ff; rv_in = rv_ff && !rsp_ready;
      load = 1'b0; wr_en = 1'b0; wr_addr = widx_ff; wr_data = 8'd0;
      rd_en = 1'b0; rd_addr = ridx_ff; pb = 8'd0;
      nw = nxt(widx_ff, size_lim);
      nr = nxt(ridx_ff, size_lim);
      case (st_ff)
         ST_IDLE: begin
            if (q_valid && !rv_ff) begin
               load = 1'b1;
               do_in = 8'd0; fe_in = 1'b0; stat_in = STAT_OK;
               if (q_item.cmd == CMD_PUSH) begin
                  if (q_item.first) st_in = ST_P_START;
                  else if (q_item.is_code) st_in = ST_P_ESC;
                  else st_in = ST_P_DATA;
               end else if (mode_ff == MODE_OVER) begin
                  ridx_in = widx_ff; hunt_in = '0; inf_in = 1'b0;
                  st_in = ST_HUNT_RD;
               end else if (mode_ff == MODE_EMPTY) begin
                  stat_in = STAT_EMPTY; st_in = ST_DONE;
               end else begin
                  st_in = ST_RD; dec_in = 1'b0; esc_in = 1'b0;
               end
            end
         end
         ST_P_START, ST_P_ESC, ST_P_DATA, ST_P_END: begin
            case (st_ff)
               ST_P_START: begin
                  pb = start_code;
                  st_in = it_ff.is_code ? ST_P_ESC : ST_P_DATA;
               end
               ST_P_ESC: begin pb = escape_code; st_in = ST_P_DATA; end
               ST_P_DATA: begin
                  pb = it_ff.is_code ? it_ff.data + 8'd1 : it_ff.data;
                  st_in = it_ff.last ? ST_P_END : ST_DONE;
               end
               default: begin pb = end_code; st_in = ST_DONE; end
            endcase
            wr_en = 1'b1; wr_data = pb; widx_in = nw;
            if (mode_ff == MODE_FULL || mode_ff == MODE_OVER) mode_in = MODE_OVER;
            else if (nw == ridx_ff) mode_in = MODE_FULL;
            else mode_in = MODE_NORMAL;
         end
         ST_HUNT_RD: begin
            rd_en = 1'b1; st_in = ST_HUNT_CHK;
         end
         ST_HUNT_CHK: begin
            if (rdata_ff == start_code) begin
               mode_in = (ridx_ff == widx_ff) ? MODE_FULL : MODE_NORMAL;
               st_in = ST_RD; dec_in = 1'b0; esc_in = 1'b0;
            end else begin
               ridx_in = nr; hunt_in = hunt_ff + (AW+1)'(1);
               if (nr == widx_ff || hunt_ff + (AW+1)'(1) >= size_lim) begin
                  mode_in = MODE_EMPTY; stat_in = STAT_EMPTY; st_in = ST_DONE;
               end else st_in = ST_HUNT_RD;
            end
         end
         ST_RD: begin
            if (!inf_ff && !dec_ff) begin
               ridx_in = nr;
               if (nr == widx_ff) begin
                  mode_in = MODE_EMPTY; stat_in = STAT_BROKE; st_in = ST_DONE;
               end else begin
                  if (mode_ff == MODE_FULL) mode_in = MODE_NORMAL;
                  dec_in = 1'b1;
               end
            end else begin
               dec_in = 1'b1; rd_en = 1'b1; st_in = ST_RD_CHK;
            end
         end
         ST_RD_CHK: begin
            // three phases by esc_ff / fe_ff(used as "at end check")
            if (!fe_ff) begin
               // rdata is payload byte (or escape second byte when esc_ff)
               ridx_in = nr;
               if (nr == widx_ff) mode_in = MODE_EMPTY;
               else if (mode_ff == MODE_FULL) mode_in = MODE_NORMAL;
               if (!esc_ff && rdata_ff == escape_code) begin
                  if (nr == widx_ff) begin
                     inf_in = 1'b0; stat_in = STAT_BROKE; st_in = ST_DONE;
                  end else begin
                     esc_in = 1'b1; st_in = ST_RD;
                  end
               end else begin
                  d_in = esc_ff ? rdata_ff - 8'd1 : rdata_ff;
                  if (nr == widx_ff) begin
                     inf_in = 1'b0; stat_in = STAT_BROKE; st_in = ST_DONE;
                  end else begin
                     fe_in = 1'b1; st_in = ST_RD;
                  end
               end
            end else begin
               do_in = d_ff;
               if (rdata_ff == end_code) begin
                  ridx_in = nr; inf_in = 1'b0;
                  if (nr == widx_ff) mode_in = MODE_EMPTY;
                  else if (mode_ff == MODE_FULL) mode_in = MODE_NORMAL;
               end else begin
                  fe_in = 1'b0; inf_in = 1'b1;
               end
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat_in != STAT_OK) begin do_in = 8'd0; fe_in = 1'b0; end
            ov_in = (mode_ff == MODE_OVER);
            rv_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_write && csr_index == CSR_SIZE) begin
         widx_in = '0; ridx_in = '0; mode_in = MODE_EMPTY; inf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; widx_ff <= '0; ridx_ff <= '0; mode_ff <= MODE_EMPTY;
         inf_ff <= 1'b0; rv_ff <= 1'b0; size_ff <= 9'd256;
      end else begin
         st_ff <= st_in; widx_ff <= widx_in; ridx_ff <= ridx_in; mode_ff <= mode_in;
         inf_ff <= inf_in; rv_ff <= rv_in;
         if (csr_write && csr_index == CSR_SIZE) size_ff <= csr_data;
      end
      if (load) it_ff <= q_item;
      hunt_ff <= hunt_in; dec_ff <= dec_in; d_ff <= d_in; esc_ff <= esc_in;
      do_ff <= do_in; fe_ff <= fe_in; stat_ff <= stat_in; ov_ff <= ov_in;
   end

`ifndef NO_ASSERTIONS
   a_idx_w: assert property (@(posedge clock) disable iff (reset)
      {1'b0, widx_ff} < size_lim) else $error("write index past size");
   a_idx_r: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ridx_ff} < size_lim) else $error("read index past size");
   a_load: assert property (@(posedge clock) disable iff (reset)
      load |-> !rv_ff) else $error("request taken with response pending");
   a_done: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DONE |=> rv_ff) else $error("response not raised");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/byte_stuffed_frame_ring_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_ring_buffer_unit: framed byte ring store
// Push requests stuff one payload byte into the ring; pop requests return
// one decoded byte with a frame end flag, status and overwrite mark.
//
// Channels: req_* request in (valid/ready), rsp_* one response per request,
// csr_* register writes (index 0 size, 1 start, 2 end, 3 escape code).
// A two deep request queue feeds a sequencer that makes one store access
// per cycle. A push writes one store byte per access and then responds; a
// pop on an empty store responds without reading, and after an overwrite a
// pop first scans the store byte by byte in a hunt for the start code. A
// queued request is taken in the cycle after the response is taken.
// Reset empties the ring, clears the indices and loads the default codes.
// A stalled response holds the sequencer; the queue still accepts up to
// two further requests.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_ring_buffer_unit
   import bsfrb_pkg::*;
#(
   parameter int STORE_DEPTH = 256
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_data_in,
   input  wire logic       req_frame_first,
   input  wire logic       req_frame_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_out,
   output logic            rsp_frame_end,
   output logic [1:0]      rsp_status,
   output logic            rsp_overwritten,
   input  wire logic       csr_write,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data
);

   logic [7:0] start_ff, end_ff, esc_ff;
   logic       q_valid, q_take;
   item_type   q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'd170; end_ff <= 8'd187; esc_ff <= 8'd204;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START: start_ff <= csr_data[7:0];
            CSR_END:   end_ff   <= csr_data[7:0];
            CSR_ESC:   esc_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   bsfrb_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_data_in,
      .req_frame_first, .req_frame_last,
      .start_code(start_ff), .end_code(end_ff), .escape_code(esc_ff),
      .q_valid, .q_take, .q_item
   );

   bsfrb_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_item, .csr_write, .csr_index, .csr_data,
      .start_code(start_ff), .end_code(end_ff), .escape_code(esc_ff),
      .rsp_valid, .rsp_ready, .rsp_data_out, .rsp_frame_end, .rsp_status,
      .rsp_overwritten
   );

endmodule
`default_nettype wire

FILE: tb/byte_stuffed_frame_ring_buffer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_ring_buffer_unit_test: self-checking bench
// Drives push/pop requests with random idling on both channels, predicts each
// response with a behavioral model of the framed ring and compares it field
// by field. Runs several size and code settings, including the extremes.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_ring_buffer_unit_test;
   import bsfrb_pkg::*;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       first;
      logic       last;
   } request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fend;
      logic [1:0] status;
      logic       over;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic [7:0] req_data_in = 8'd0;
   logic req_frame_first = 1'b0;
   logic req_frame_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_data_out;
   logic rsp_frame_end;
   logic [1:0] rsp_status;
   logic rsp_overwritten;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_SIZE;
   logic [8:0] csr_data = 9'd0;

   byte_stuffed_frame_ring_buffer_unit dut (.*);

   always #10 clock = ~clock;

   // ring model
   logic [7:0] ring [0:255];
   int unsigned wr_idx, rd_idx, ring_size;
   mode_type fill;
   logic in_frame;
   logic [7:0] code_start, code_end, code_esc;

   request_type pending_reqs [$];
   response_type expected_rsps [$];
   int send_idle_pct, recv_idle_pct;
   int unsigned errors = 0;
   int unsigned stall_cycles = 0;

   function automatic int unsigned step_idx(int unsigned i);
      return (i + 1 >= ring_size) ? 0 : i + 1;
   endfunction

   function automatic void ring_put(logic [7:0] b);
      if (fill == MODE_FULL || fill == MODE_OVER) fill = MODE_OVER;
      ring[wr_idx] = b;
      wr_idx = step_idx(wr_idx);
      if (wr_idx == rd_idx && fill != MODE_OVER) fill = MODE_FULL;
      else if (fill == MODE_EMPTY) fill = MODE_NORMAL;
   endfunction

   function automatic void ring_advance();
      rd_idx = step_idx(rd_idx);
      if (rd_idx == wr_idx) fill = MODE_EMPTY;
      else if (fill == MODE_FULL) fill = MODE_NORMAL;
   endfunction

   function automatic logic [1:0] ring_pop(output logic [7:0] d, output logic fe);
      logic found;
      d = 8'd0;
      fe = 1'b0;
      if (fill == MODE_OVER) begin
         found = 1'b0;
         rd_idx = wr_idx;
         for (int n = 0; n < ring_size; n++) begin
            if (ring[rd_idx] == code_start) begin
               found = 1'b1;
               break;
            end
            rd_idx = step_idx(rd_idx);
            if (rd_idx == wr_idx) break;
         end
         in_frame = 1'b0;
         if (!found) begin
            fill = MODE_EMPTY;
            return STAT_EMPTY;
         end
         fill = (rd_idx == wr_idx) ? MODE_FULL : MODE_NORMAL;
      end
      if (fill == MODE_EMPTY) return STAT_EMPTY;
      if (!in_frame) begin
         ring_advance();
         if (fill == MODE_EMPTY) return STAT_BROKE;
      end
      d = ring[rd_idx];
      ring_advance();
      if (d == code_esc) begin
         if (fill == MODE_EMPTY) begin
            in_frame = 1'b0;
            d = 8'd0;
            return STAT_BROKE;
         end
         d = ring[rd_idx] - 8'd1;
         ring_advance();
      end
      if (fill == MODE_EMPTY) begin
         in_frame = 1'b0;
         d = 8'd0;
         return STAT_BROKE;
      end
      if (ring[rd_idx] == code_end) begin
         fe = 1'b1;
         ring_advance();
         in_frame = 1'b0;
      end else begin
         in_frame = 1'b1;
      end
      return STAT_OK;
   endfunction

   function automatic response_type predict_response(request_type r);
      response_type p;
      p = '0;
      if (r.cmd == CMD_PUSH) begin
         if (r.first) ring_put(code_start);
         if (r.data == code_start || r.data == code_end || r.data == code_esc) begin
            ring_put(code_esc);
            ring_put(r.data + 8'd1);
         end else begin
            ring_put(r.data);
         end
         if (r.last) ring_put(code_end);
      end else begin
         p.status = ring_pop(p.data, p.fend);
         if (p.status != STAT_OK) begin
            p.data = 8'd0;
            p.fend = 1'b0;
         end
      end
      p.over = (fill == MODE_OVER);
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            request_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_command <= r.cmd;
            req_data_in <= r.data;
            req_frame_first <= r.first;
            req_frame_last <= r.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (req_valid && req_ready)
            expected_rsps.push_back(predict_response({req_command, req_data_in,
                                                      req_frame_first, req_frame_last}));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with none expected");
               errors++;
            end else begin
               response_type e;
               e = expected_rsps.pop_front();
               if (rsp_data_out !== e.data) begin
                  $error("data_out expected %0h got %0h", e.data, rsp_data_out);
                  errors++;
               end
               if (rsp_frame_end !== e.fend) begin
                  $error("frame_end expected %0b got %0b", e.fend, rsp_frame_end);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_overwritten !== e.over) begin
                  $error("overwritten expected %0b got %0b", e.over, rsp_overwritten);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic request_type make_push(logic [7:0] d, logic f, logic l);
      return {CMD_PUSH, d, f, l};
   endfunction

   function automatic request_type make_pop();
      return {CMD_POP, 8'($urandom), 1'($urandom), 1'($urandom)};
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SIZE: begin
            ring_size = (val < 1) ? 1 : (val > 256 ? 256 : val);
            wr_idx = 0;
            rd_idx = 0;
            fill = MODE_EMPTY;
            in_frame = 1'b0;
         end
         CSR_START: code_start = val[7:0];
         CSR_END: code_end = val[7:0];
         default: code_esc = val[7:0];
      endcase
   endtask

   // writes frames until the ring has wrapped at least once, so no pop
   // reaches an unwritten entry
   task automatic fill_ring();
      for (int n = 0; n < ring_size + 2; n++)
         pending_reqs.push_back(make_push(8'($urandom), (n % 4) == 0, (n % 4) == 3));
   endtask

   task automatic random_phase(int count);
      int k;
      k = 0;
      fill_ring();
      while (k < count) begin
         int len, sel, npop;
         sel = $urandom_range(9);
         if (sel < 7) begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) begin
               logic [7:0] d;
               case ($urandom_range(4))
                  0: d = code_start;
                  1: d = code_end;
                  2: d = code_esc;
                  default: d = 8'($urandom);
               endcase
               pending_reqs.push_back(make_push(d, j == 0, j == len - 1));
            end
            npop = $urandom_range(1, len + 3);
            for (int j = 0; j < npop; j++)
               pending_reqs.push_back(make_pop());
            k += 2 * len;
         end else begin
            if ($urandom_range(1)) pending_reqs.push_back(make_pop());
            else pending_reqs.push_back(make_push(8'($urandom), 1'($urandom), 1'($urandom)));
            k++;
         end
      end
      wait_drained();
   endtask

   initial begin
      code_start = 8'd170;
      code_end = 8'd187;
      code_esc = 8'd204;
      ring_size = 256;
      wr_idx = 0;
      rd_idx = 0;
      fill = MODE_EMPTY;
      in_frame = 1'b0;
      send_idle_pct = 6;
      recv_idle_pct = 48;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, code bytes, extremes, broken frame, overwrite
      pending_reqs.push_back(make_pop());
      pending_reqs.push_back(make_push(8'd0, 1'b1, 1'b0));
      pending_reqs.push_back(make_push(8'd170, 1'b0, 1'b0));
      pending_reqs.push_back(make_push(8'd187, 1'b0, 1'b0));
      pending_reqs.push_back(make_push(8'd204, 1'b0, 1'b0));
      pending_reqs.push_back(make_push(8'd255, 1'b0, 1'b1));
      repeat (6) pending_reqs.push_back(make_pop());
      pending_reqs.push_back(make_push(8'h5a, 1'b1, 1'b0));
      repeat (3) pending_reqs.push_back(make_pop());
      wait_drained();

      write_csr(CSR_SIZE, 9'd8);
      write_csr(CSR_START, 9'd254);
      write_csr(CSR_END, 9'd0);
      write_csr(CSR_ESC, 9'd255);
      pending_reqs.push_back(make_push(8'd255, 1'b1, 1'b1));
      pending_reqs.push_back(make_push(8'd0, 1'b1, 1'b1));
      pending_reqs.push_back(make_push(8'd254, 1'b1, 1'b1));
      pending_reqs.push_back(make_push(8'd7, 1'b1, 1'b1));
      repeat (4) pending_reqs.push_back(make_pop());
      wait_drained();

      random_phase(50);
      send_idle_pct = 48;
      recv_idle_pct = 6;
      write_csr(CSR_SIZE, 9'd1);
      random_phase(15);
      write_csr(CSR_SIZE, 9'd511);
      write_csr(CSR_START, 9'd170);
      write_csr(CSR_END, 9'd187);
      write_csr(CSR_ESC, 9'd204);
      random_phase(30);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_SIZE, 9'd0);
      random_phase(15);
      write_csr(CSR_SIZE, 9'd13);
      write_csr(CSR_START, 9'd1);
      write_csr(CSR_END, 9'd2);
      write_csr(CSR_ESC, 9'd3);
      random_phase(50);

      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: byte_stuffed_frame_ring_buffer_unit.f
hw/rtl/bsfrb_pkg.sv
hw/rtl/bsfrb_front.sv
hw/rtl/bsfrb_back.sv
hw/rtl/byte_stuffed_frame_ring_buffer_unit.sv
tb/byte_stuffed_frame_ring_buffer_unit_test.sv
